// ----- rtl/sgcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sgcr_pkg;

  // Panel geometry
  localparam logic [15:0] SCREEN_WIDTH  = 16'd320;
  localparam logic [15:0] SCREEN_HEIGHT = 16'd240;

  // Glyph geometry: 7 rows of 5 cells, row-major
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;

  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

  // Character codes held in the font ROM
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;

  typedef logic [GLYPH_CELLS-1:0] glyph_t;

  // One queued draw transaction, glyph already decoded
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  scale;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    glyph_t      glyph;
  } job_t;

  // Row 0 in the top bits, column 0 at the MSB of each row.
  // Cell i (row-major) sits at bit GLYPH_CELLS-1-i.
  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    case (code)
      CH_DASH: g = {5'b00000, 5'b00000, 5'b00000, 5'b11111, 5'b00000, 5'b00000, 5'b00000};
      CH_3:    g = {5'b11110, 5'b00001, 5'b00001, 5'b01110, 5'b00001, 5'b00001, 5'b11110};
      CH_B:    g = {5'b11110, 5'b10001, 5'b10001, 5'b11110, 5'b10001, 5'b10001, 5'b11110};
      CH_E:    g = {5'b11111, 5'b10000, 5'b10000, 5'b11110, 5'b10000, 5'b10000, 5'b11111};
      CH_H:    g = {5'b10001, 5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001, 5'b10001};
      CH_I:    g = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      CH_L:    g = {5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b11111};
      CH_O:    g = {5'b01110, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b01110};
      CH_S:    g = {5'b01111, 5'b10000, 5'b10000, 5'b01110, 5'b00001, 5'b00001, 5'b11110};
      CH_T:    g = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100};
      CH_X:    g = {5'b10001, 5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001, 5'b10001};
      // space and unknown codes render blank
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sgcr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgcr_front
  import sgcr_pkg::*;
(
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic        [7:0]  in_char_code,
  input  wire logic        [7:0]  in_scale,
  input  wire logic        [15:0] in_fg_color,
  input  wire logic        [15:0] in_bg_color,
  input  wire logic               q_full,
  output logic                    push,
  output job_t                    push_job
);

  assign busy = q_full;
  assign push = start && !q_full;

  // decode glyph on the way in; positions carried as raw bits
  always_comb begin
    push_job.pos_x    = $unsigned(in_pos_x);
    push_job.pos_y    = $unsigned(in_pos_y);
    push_job.scale    = in_scale;
    push_job.fg_color = in_fg_color;
    push_job.bg_color = in_bg_color;
    push_job.glyph    = font_glyph(in_char_code);
  end

endmodule

`default_nettype wire

// ----- rtl/sgcr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgcr_queue
  import sgcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job,
  output logic      q_full
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_job   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sgcr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgcr_back
  import sgcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  job_t             q_job,
  output logic             pop,
  output logic             out_valid,
  output logic [8:0]       out_rect_x,
  output logic [7:0]       out_rect_y,
  output logic [7:0]       out_rect_w,
  output logic [7:0]       out_rect_h,
  output logic [15:0]      out_fill_color,
  output logic             out_drawn,
  output logic             out_last_cell
);

  // sequencer state
  logic        active_r;
  logic [2:0]  row_r, col_r;
  logic [15:0] base_x_r, cx_r, cy_r;
  logic [7:0]  scale_r;
  logic [15:0] fg_r, bg_r;
  glyph_t      glyph_r;

  // output register
  logic        valid_r;
  logic [8:0]  rect_x_r;
  logic [7:0]  rect_y_r, rect_w_r, rect_h_r;
  logic [15:0] color_r;
  logic        drawn_r, last_r;

  logic        last_now;
  logic        drawn_c;
  logic [16:0] x_end, y_end;
  logic [15:0] x_room, y_room;
  logic [7:0]  w_c, h_c;

  assign last_now = active_r && (row_r == LAST_ROW) && (col_r == LAST_COL);
  assign pop      = q_valid && (!active_r || last_now);

  always_comb begin
    drawn_c = (cx_r < SCREEN_WIDTH) && (cy_r < SCREEN_HEIGHT) && (scale_r != 8'd0);
    x_end   = {1'b0, cx_r} + {9'd0, scale_r};
    y_end   = {1'b0, cy_r} + {9'd0, scale_r};
    x_room  = SCREEN_WIDTH - cx_r;
    y_room  = SCREEN_HEIGHT - cy_r;
    w_c     = (x_end > {1'b0, SCREEN_WIDTH})  ? x_room[7:0] : scale_r;
    h_c     = (y_end > {1'b0, SCREEN_HEIGHT}) ? y_room[7:0] : scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
      end else if (last_now) begin
        active_r <= 1'b0;
      end
    end
  end

  // walk the cells: corners advance by scale, one cell per cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      row_r    <= 3'd0;
      col_r    <= 3'd0;
      base_x_r <= q_job.pos_x;
      cx_r     <= q_job.pos_x;
      cy_r     <= q_job.pos_y;
      scale_r  <= q_job.scale;
      fg_r     <= q_job.fg_color;
      bg_r     <= q_job.bg_color;
      glyph_r  <= q_job.glyph;
    end else if (active_r) begin
      glyph_r <= {glyph_r[GLYPH_CELLS-2:0], 1'b0};
      if (col_r == LAST_COL) begin
        col_r <= 3'd0;
        row_r <= row_r + 3'd1;
        cx_r  <= base_x_r;
        cy_r  <= cy_r + {8'd0, scale_r};
      end else begin
        col_r <= col_r + 3'd1;
        cx_r  <= cx_r + {8'd0, scale_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      rect_x_r <= drawn_c ? cx_r[8:0] : 9'd0;
      rect_y_r <= drawn_c ? cy_r[7:0] : 8'd0;
      rect_w_r <= drawn_c ? w_c : 8'd0;
      rect_h_r <= drawn_c ? h_c : 8'd0;
      color_r  <= glyph_r[GLYPH_CELLS-1] ? fg_r : bg_r;
      drawn_r  <= drawn_c;
      last_r   <= last_now;
    end
  end

  assign out_valid      = valid_r;
  assign out_rect_x     = rect_x_r;
  assign out_rect_y     = rect_y_r;
  assign out_rect_w     = rect_w_r;
  assign out_rect_h     = rect_h_r;
  assign out_fill_color = color_r;
  assign out_drawn      = drawn_r;
  assign out_last_cell  = last_r && valid_r;

endmodule

`default_nettype wire

// ----- rtl/scaled_glyph_cell_rasterizer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scaled glyph cell rasterizer: 5x7 bitmap font character generator.
// Input channel: a draw transaction (in_pos_x/in_pos_y signed, in_char_code,
// in_scale, in_fg_color, in_bg_color) is taken at a clock edge with start
// high and busy low. Codes not in the 12-glyph font render blank.
// Output channel: 35 cell rectangles per transaction, row-major, each shown
// for exactly one cycle with out_valid high; out_last_cell flags the 35th.
// The receiver cannot stall; results must be taken as they come.
// An accepted transaction is written into the queue, popped into the
// sequencer registers, and its rectangles leave through the output register.
// The back end puts out one rectangle per cycle, set by the cell sequencer;
// successive transactions stream with no gap between their rectangle bursts.
// Structure: the front end decodes the glyph and writes a 2-entry queue;
// the back end pops a job and walks its cells, stepping the corner by
// scale and clipping at the panel edge.
// busy is high while the queue is full, i.e. up to two transactions can
// wait behind the one being drawn.
// Reset (synchronous, rst_n low) empties the queue, stops the sequencer
// and drops out_valid; payload registers are not cleared.

module scaled_glyph_cell_rasterizer
  import sgcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic        [7:0]  in_char_code,
  input  wire logic        [7:0]  in_scale,
  input  wire logic        [15:0] in_fg_color,
  input  wire logic        [15:0] in_bg_color,
  output logic                    out_valid,
  output logic             [8:0]  out_rect_x,
  output logic             [7:0]  out_rect_y,
  output logic             [7:0]  out_rect_w,
  output logic             [7:0]  out_rect_h,
  output logic             [15:0] out_fill_color,
  output logic                    out_drawn,
  output logic                    out_last_cell
);

  logic push, pop, q_valid, q_full;
  job_t push_job, q_job;

  // front: accept and decode
  sgcr_front u_front (
    .start        (start),
    .busy         (busy),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_char_code (in_char_code),
    .in_scale     (in_scale),
    .in_fg_color  (in_fg_color),
    .in_bg_color  (in_bg_color),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  // decoupling queue between front and back
  sgcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_full   (q_full)
  );

  // back: cell sequencer and registered result port
  sgcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_fill_color (out_fill_color),
    .out_drawn      (out_drawn),
    .out_last_cell  (out_last_cell)
  );

endmodule

`default_nettype wire

// ----- rtl/sgcr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgcr_checker
  import sgcr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic [8:0]  out_rect_x,
  input wire logic [7:0]  out_rect_y,
  input wire logic [7:0]  out_rect_w,
  input wire logic [7:0]  out_rect_h,
  input wire logic        out_drawn,
  input wire logic        out_last_cell
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_cell |-> out_valid)
    else $error("last_cell without result strobe");

  a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drawn) |->
      (out_rect_x == 9'd0) && (out_rect_y == 8'd0) &&
      (out_rect_w == 8'd0) && (out_rect_h == 8'd0))
    else $error("undrawn rectangle with nonzero geometry");

  a_drawn_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drawn) |->
      ({7'd0, out_rect_x} < SCREEN_WIDTH) && ({8'd0, out_rect_y} < SCREEN_HEIGHT) &&
      (out_rect_w != 8'd0) && (out_rect_h != 8'd0) &&
      ({7'd0, out_rect_x} + {8'd0, out_rect_w} <= SCREEN_WIDTH) &&
      ({8'd0, out_rect_y} + {8'd0, out_rect_h} <= SCREEN_HEIGHT))
    else $error("drawn rectangle not clipped to screen");

endmodule

bind scaled_glyph_cell_rasterizer sgcr_checker u_sgcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_rect_x    (out_rect_x),
  .out_rect_y    (out_rect_y),
  .out_rect_w    (out_rect_w),
  .out_rect_h    (out_rect_h),
  .out_drawn     (out_drawn),
  .out_last_cell (out_last_cell)
);

`default_nettype wire
